@@ src/hsar_pkg.sv @@
// Package for the handshake and acknowledgement receiver.
// Holds the sequence width, the connection states, the command codes and the register indexes.
// Depends on nothing.
`timescale 1ns / 1ps

package hsar_pkg;

	localparam int SEQ_BITS = 32;

	typedef logic [SEQ_BITS-1:0] seq_t;

	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_WAIT_SYN    = 3'd1,
		ST_WAIT_ACK    = 3'd2,
		ST_ESTABLISHED = 3'd3,
		ST_CLOSED      = 3'd4
	} conn_state_t;

	typedef enum logic [1:0] {
		MODE_HEADER = 2'd0,
		MODE_LISTEN = 2'd1,
		MODE_CLOSE  = 2'd2
	} mode_t;

	localparam logic REG_LOCAL_PORT = 1'b0;
	localparam logic REG_DATA_START = 1'b1;

	localparam logic [31:0] DATA_START_RESET = 32'd20;

	localparam int IN_DATA_BITS  = 72;
	localparam int OUT_DATA_BITS = 88;

	// One received item as held in the input register.
	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] dst_port;
		logic [15:0] src_port;
		logic        syn_flag;
		logic        ack_flag;
		seq_t        rx_seq;
	} rx_item_t;

	// One result item as held in the output register.
	typedef struct packed {
		logic        reply_valid;
		logic        reply_kind;
		logic [31:0] reply_seq;
		logic [31:0] reply_ack_num;
		logic [15:0] reply_port;
		logic        deliver;
		logic        port_error;
		logic [2:0]  conn_state;
	} result_t;

endpackage

@@ src/handshake_and_ack_receiver.sv @@
// Receiver of a stop-and-wait link with a three-way handshake: top level.
// Depends on hsar_pkg for the state codes, command codes and item types.
`timescale 1ns / 1ps

// The block takes one item per clock cycle when the output side keeps taking results, and
// gives exactly one result item for each input item after it has passed through the input
// register and then the result register. The connection state, the expected and own
// sequence numbers and the peer port are updated in the cycle an item moves from the input
// register into the result register, so the next item sees them at once. A command in
// s_tuser (listen or close) or a received header in s_tdata is taken; a header to the wrong
// port only raises port_error. The configuration port is always ready and must only be
// written while no item is in flight.
module handshake_and_ack_receiver (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input items.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// dst_port[15:0], src_port[31:16], syn_flag[32], ack_flag[33], rx_seq[65:34], zero fill
	input  logic [hsar_pkg::IN_DATA_BITS-1:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]                        s_tuser,
	// Result items.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// reply_valid[0], reply_seq[32:1], reply_ack_num[64:33], reply_port[80:65],
	// deliver[81], port_error[82], conn_state[85:83], zero fill
	output logic [hsar_pkg::OUT_DATA_BITS-1:0] m_tdata,
	// reply_kind[0]
	output logic                              m_tuser,
	// Configuration writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [31:0]                       cfg_data
);
	import hsar_pkg::*;

	logic [15:0] local_port_q;
	logic [31:0] data_start_q;

	conn_state_t state_q, state_nxt;
	seq_t        expected_q, expected_nxt;
	seq_t        own_q, own_nxt;
	logic [15:0] peer_q, peer_nxt;

	logic     item_valid_s1;
	rx_item_t item_s1;
	logic     advance;

	logic     res_valid_s2;
	result_t  res_s2;
	result_t  res_nxt;

	logic     rv, kind, deliver, perr;
	seq_t     rseqo;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_port_q <= '0;
			data_start_q <= DATA_START_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LOCAL_PORT: local_port_q <= cfg_data[15:0];
				REG_DATA_START: data_start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the result register is free or being emptied.
	assign advance  = item_valid_s1 && (!res_valid_s2 || m_tready);
	assign s_tready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			item_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode     <= s_tuser;
			item_s1.dst_port <= s_tdata[15:0];
			item_s1.src_port <= s_tdata[31:16];
			item_s1.syn_flag <= s_tdata[32];
			item_s1.ack_flag <= s_tdata[33];
			item_s1.rx_seq   <= s_tdata[34 +: SEQ_BITS];
		end
	end

	always_comb begin
		state_nxt    = state_q;
		expected_nxt = expected_q;
		own_nxt      = own_q;
		peer_nxt     = peer_q;
		rv           = 1'b0;
		kind         = 1'b0;
		deliver      = 1'b0;
		perr         = 1'b0;
		rseqo        = '0;
		unique case (item_s1.mode)
			MODE_LISTEN: state_nxt = ST_WAIT_SYN;
			MODE_CLOSE:  state_nxt = ST_CLOSED;
			MODE_HEADER: begin
				if (item_s1.dst_port != local_port_q) begin
					perr = 1'b1;
				end else if (item_s1.syn_flag && item_s1.ack_flag &&
						state_q == ST_ESTABLISHED) begin
					// A repeated SYN-ACK from the peer: acknowledge again.
					rv    = 1'b1;
					rseqo = own_q;
				end else if (item_s1.syn_flag && state_q == ST_WAIT_ACK) begin
					// Our SYN-ACK was lost, so it is sent again.
					peer_nxt = item_s1.src_port;
					rv       = 1'b1;
					kind     = 1'b1;
				end else if (item_s1.rx_seq == expected_q) begin
					if (item_s1.syn_flag && state_q == ST_WAIT_SYN) begin
						expected_nxt = expected_q + 1'b1;
						peer_nxt     = item_s1.src_port;
						rv           = 1'b1;
						kind         = 1'b1;
						state_nxt    = ST_WAIT_ACK;
					end else if (item_s1.ack_flag && state_q == ST_WAIT_ACK) begin
						state_nxt    = ST_ESTABLISHED;
						expected_nxt = data_start_q[SEQ_BITS-1:0];
					end else if (state_q == ST_ESTABLISHED) begin
						deliver      = 1'b1;
						expected_nxt = expected_q + 1'b1;
						rv           = 1'b1;
						rseqo        = own_q;
					end
				end else begin
					// Out of order: duplicate acknowledgement.
					rv      = 1'b1;
					rseqo   = own_q;
					own_nxt = own_q + 1'b1;
				end
			end
			default: ;
		endcase

		res_nxt.reply_valid   = rv;
		res_nxt.reply_kind    = rv & kind;
		res_nxt.reply_seq     = rv ? 32'(rseqo) : '0;
		res_nxt.reply_ack_num = rv ? 32'(expected_nxt) : '0;
		res_nxt.reply_port    = rv ? peer_nxt : '0;
		res_nxt.deliver       = deliver;
		res_nxt.port_error    = perr;
		res_nxt.conn_state    = state_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			expected_q <= '0;
			own_q      <= '0;
			peer_q     <= '0;
		end else if (advance) begin
			state_q    <= state_nxt;
			expected_q <= expected_nxt;
			own_q      <= own_nxt;
			peer_q     <= peer_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = res_valid_s2;
	assign m_tuser  = res_s2.reply_kind;
	assign m_tdata  = {2'b00, res_s2.conn_state, res_s2.port_error, res_s2.deliver,
		res_s2.reply_port, res_s2.reply_ack_num, res_s2.reply_seq, res_s2.reply_valid};

	// A rejected header leaves the whole connection state untouched.
	a_perr_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && perr) |=> ($stable(state_q) && $stable(expected_q) &&
			$stable(own_q) && $stable(peer_q)))
		else $error("port error changed connection state");

	// A rejected header gives neither a reply nor a delivery.
	a_perr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.port_error) |-> (!res_s2.reply_valid && !res_s2.deliver))
		else $error("port error result carries a reply");

	// Delivery only happens on an established link and is always acknowledged.
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.deliver) |->
			(res_s2.reply_valid && res_s2.conn_state == ST_ESTABLISHED))
		else $error("delivery outside established state");

	// A SYN-ACK is only sent while waiting for the final ACK.
	a_synack: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.reply_kind) |->
			(res_s2.reply_valid && res_s2.conn_state == ST_WAIT_ACK &&
			res_s2.reply_seq == '0))
		else $error("SYN-ACK in wrong state");

	// A result that waits for the output side is not overwritten.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(res_s2)))
		else $error("stalled result lost");

endmodule
